@@ hw/rtl/tvi_pkg.sv @@
package tvi_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int COORD_W     = 15;
    localparam int IN_SAMPLE_W = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 64;

    // Field positions inside the slave tdata word
    localparam int X_LSB = 0;
    localparam int Y_LSB = X_LSB + COORD_W;
    localparam int Z_LSB = Y_LSB + COORD_W;
    localparam int S_LSB = Z_LSB + COORD_W;

    // Command carried on the slave tuser bit
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 6'd32;

    // Corner counter: bit 2 selects x, bit 1 selects y, bit 0 selects z
    localparam int                  CORNER_W    = 3;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

    // Output saturation bounds
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    // Controller to datapath commands
    typedef struct packed {
        logic                wr;
        logic                load;
        logic                issue;
        logic [CORNER_W-1:0] corner;
        logic                out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hw/rtl/tvi_ctrl.sv @@
module tvi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic              i_s_axis_tuser,
    input  tvi_pkg::t_dp_stat i_stat,
    output tvi_pkg::t_dp_cmd  o_cmd
);
    import tvi_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CORNER_W-1:0] r_corner, n_corner;
    logic                w_accept;

    // Take items only between queries
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Commands to the datapath
    always_comb begin
        o_cmd.wr       = w_accept && (i_s_axis_tuser == CMD_WRITE);
        o_cmd.load     = w_accept && (i_s_axis_tuser == CMD_QUERY);
        o_cmd.issue    = (r_state == ST_READ);
        o_cmd.corner   = r_corner;
        o_cmd.out_load = ((r_state == ST_WAIT) && i_stat.done && i_stat.out_free)
                      || ((r_state == ST_HOLD) && i_stat.out_free);
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state  = ST_READ;
                    n_corner = '0;
                end
            end
            ST_READ: begin
                n_corner = r_corner + CORNER_W'(1);
                if (r_corner == LAST_CORNER) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    n_state = i_stat.out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
        end
    end

    // A finished blend only arrives while the controller waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.done |-> (r_state == ST_WAIT))
        else $error("blend finished outside the wait state");

    // A query starts its corner reads at the first corner
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_READ) && (r_corner == '0))
        else $error("query did not start at the first corner");

    // Eight reads, then wait
    a_read_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) && (r_corner == LAST_CORNER) |=> (r_state == ST_WAIT))
        else $error("corner reads did not end after the last corner");

endmodule

@@ hw/rtl/tvi_dp.sv @@
module tvi_dp #(
    parameter int DIM_MAX      = 32,
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [tvi_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    input  tvi_pkg::t_dp_cmd               i_cmd,
    output tvi_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tvi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvi_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [tvi_pkg::OUT_W-1:0]      o_m_axis_tdata,
    output logic                           o_m_axis_tuser
);
    import tvi_pkg::*;

    localparam int IW    = $clog2(DIM_MAX);
    localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int WW    = FRAC_BITS + 1;
    localparam int TW    = SW + FRAC_BITS;
    localparam int UW    = SW + 2 * FRAC_BITS;
    localparam int RW    = SW + 3 * FRAC_BITS;
    localparam int SH    = 3 * FRAC_BITS;
    localparam logic [WW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Last index in use for a size register
    function automatic logic [IW-1:0] f_last(input logic [CFG_W-1:0] sz);
        logic [IW-1:0] res;
        if (sz == '0) begin
            res = '0;
        end else if (int'(sz) > DIM_MAX) begin
            res = IW'(DIM_MAX - 1);
        end else begin
            res = IW'(int'(sz) - 1);
        end
        return res;
    endfunction

    // Linear voxel address, x major
    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] x,
                                             input logic [IW-1:0] y,
                                             input logic [IW-1:0] z);
        return AW'(32'(x) * DIM_MAX * DIM_MAX + 32'(y) * DIM_MAX + 32'(z));
    endfunction

    logic [CFG_W-1:0]   r_size [3];
    logic [IW-1:0]      w_last [3];
    logic [COORD_W-1:0] w_coord [3];
    logic [COORD_W-1:0] w_fl [3];
    logic [IW-1:0]      w_lo [3];
    logic [IW-1:0]      w_hi [3];
    logic [FRAC_BITS-1:0] w_frac [3];
    logic [2:0]         w_clip;
    logic [2:0]         w_in_range;

    logic [IW-1:0]      r_lo [3];
    logic [IW-1:0]      r_hi [3];
    logic [WW-1:0]      r_w0 [3];
    logic [WW-1:0]      r_w1 [3];
    logic               r_clip;

    logic signed [IN_SAMPLE_W-1:0] w_sample;
    logic signed [SW-1:0]          w_sample_sw;
    logic [SW-1:0]                 w_wdata;
    logic [AW-1:0]                 w_wr_addr;
    logic [AW-1:0]                 w_rd_addr;
    logic [AW-1:0]                 w_addr;
    logic                          w_we;

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] r_rdata;

    logic                r_rd_vld, r_p1_vld, r_tz_vld, r_p2_vld, r_ty_vld, r_p3_vld;
    logic [CORNER_W-1:0] r_rd_k, r_p1_k, r_tz_k, r_p2_k, r_ty_k, r_p3_k;
    logic [TW-1:0]       r_p1, r_tz;
    logic [UW-1:0]       r_p2, r_ty;
    logic [RW-1:0]       r_p3, r_tx;
    logic                r_done;
    logic [WW-1:0]       w_wz, w_wy, w_wx;

    logic [RW:0]          w_sum;
    logic [SW-1:0]        w_res;
    logic signed [SW-1:0] w_val;
    int                   w_val_int;
    logic [OUT_W-1:0]     w_sat;

    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;
    logic             r_out_clip;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= CFG_SIZE_RESET;
            r_size[1] <= CFG_SIZE_RESET;
            r_size[2] <= CFG_SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size[0] <= i_cfg_data;
                CFG_SIZE_Y: r_size[1] <= i_cfg_data;
                CFG_SIZE_Z: r_size[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_coord[0] = i_s_axis_tdata[X_LSB +: COORD_W];
    assign w_coord[1] = i_s_axis_tdata[Y_LSB +: COORD_W];
    assign w_coord[2] = i_s_axis_tdata[Z_LSB +: COORD_W];

    // Per-axis floor, neighbor and fraction
    for (genvar g = 0; g < 3; g++) begin : g_axis
        assign w_last[g]     = f_last(r_size[g]);
        assign w_fl[g]       = w_coord[g] >> FRAC_BITS;
        assign w_clip[g]     = 32'(w_fl[g]) > 32'(w_last[g]);
        assign w_lo[g]       = w_clip[g] ? w_last[g] : IW'(w_fl[g]);
        assign w_hi[g]       = (w_lo[g] == w_last[g]) ? w_last[g] : w_lo[g] + IW'(1);
        assign w_frac[g]     = FRAC_BITS'(32'(w_coord[g]) & ((32'd1 << FRAC_BITS) - 32'd1));
        assign w_in_range[g] = 32'(w_coord[g]) <= 32'(w_last[g]);
    end

    // Latch the query geometry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= w_lo[a];
                r_hi[a] <= w_hi[a];
                r_w0[a] <= ONE - {1'b0, w_frac[a]};
                r_w1[a] <= {1'b0, w_frac[a]};
            end
            r_clip <= |w_clip;
        end
    end

    // Store samples biased to unsigned
    assign w_sample    = i_s_axis_tdata[S_LSB +: IN_SAMPLE_W];
    assign w_sample_sw = SW'(w_sample);
    assign w_wdata     = {~w_sample_sw[SW-1], w_sample_sw[SW-2:0]};
    assign w_wr_addr   = f_addr(w_coord[0][IW-1:0], w_coord[1][IW-1:0], w_coord[2][IW-1:0]);
    assign w_rd_addr   = f_addr(i_cmd.corner[2] ? r_hi[0] : r_lo[0],
                                i_cmd.corner[1] ? r_hi[1] : r_lo[1],
                                i_cmd.corner[0] ? r_hi[2] : r_lo[2]);
    assign w_addr      = i_cmd.issue ? w_rd_addr : w_wr_addr;
    assign w_we        = i_cmd.wr && (&w_in_range);

    // Single-port volume memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_wdata;
        end
        r_rdata <= mem[w_addr];
    end

    assign w_wz = r_rd_k[0] ? r_w1[2] : r_w0[2];
    assign w_wy = r_tz_k[1] ? r_w1[1] : r_w0[1];
    assign w_wx = r_ty_k[2] ? r_w1[0] : r_w0[0];

    // Blend pipeline: z pairs, then y pairs, then x pair
    always_ff @(posedge i_clk) begin
        r_p1 <= TW'(r_rdata) * TW'(w_wz);
        r_p2 <= UW'(r_tz) * UW'(w_wy);
        r_p3 <= RW'(r_ty) * RW'(w_wx);
        r_rd_k <= i_cmd.corner;
        r_p1_k <= r_rd_k;
        r_tz_k <= r_p1_k;
        r_p2_k <= r_tz_k;
        r_ty_k <= r_p2_k;
        r_p3_k <= r_ty_k;
        if (r_p1_vld) begin
            r_tz <= r_p1_k[0] ? r_tz + r_p1 : r_p1;
        end
        if (r_p2_vld) begin
            r_ty <= r_p2_k[1] ? r_ty + r_p2 : r_p2;
        end
        if (r_p3_vld) begin
            r_tx <= r_p3_k[2] ? r_tx + r_p3 : r_p3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_tz_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_ty_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            r_p1_vld <= r_rd_vld;
            r_tz_vld <= r_p1_vld && r_p1_k[0];
            r_p2_vld <= r_tz_vld;
            r_ty_vld <= r_p2_vld && r_p2_k[1];
            r_p3_vld <= r_ty_vld;
            r_done   <= r_p3_vld && r_p3_k[2];
        end
    end

    // Round to nearest, remove bias, saturate
    assign w_sum     = {1'b0, r_tx} + ((RW + 1)'(1) << (SH - 1));
    assign w_res     = w_sum[SH +: SW];
    assign w_val     = {~w_res[SW-1], w_res[SW-2:0]};
    assign w_val_int = int'(w_val);

    always_comb begin
        if (w_val_int > OUT_MAX) begin
            w_sat = OUT_W'(OUT_MAX);
        end else if (w_val_int < OUT_MIN) begin
            w_sat = OUT_W'(OUT_MIN);
        end else begin
            w_sat = OUT_W'(w_val_int);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= w_sat;
            r_out_clip <= r_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_clip;

    assign o_stat.done     = r_done;
    assign o_stat.out_free = !r_out_vld || i_m_axis_tready;

    // Pipeline is empty when the blend completes
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_rd_vld || r_p1_vld || r_tz_vld || r_p2_vld || r_ty_vld || r_p3_vld))
        else $error("blend completed with corners still in flight");

    // Writes never share the memory port with corner reads
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr && i_cmd.issue))
        else $error("write and corner read in the same cycle");

    // Never overwrite a result that has not been transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_m_axis_tready))
        else $error("result overwritten before transfer");

endmodule

@@ hw/rtl/trilinear_volume_interpolator.sv @@
// Channel  Direction  Handshake                     Payload
// s_axis   in         i_s_axis_tvalid/o_s_axis_tready tdata: x, y, z, sample; tuser: command
// m_axis   out        o_m_axis_tvalid/i_m_axis_tready tdata: interpolated; tuser: clipped
// cfg      in         i_cfg_valid/o_cfg_ready       index, size value
//
// A write leaves the controller idle; the next item is accepted the cycle after.
// A query loads its result into the output register after eight corner reads from the
// single-port volume memory, one per cycle, and a six-stage blend pipeline; the next
// item is accepted from the cycle after the load.
// Reset (synchronous, active low) sets all sizes to 32; voxel contents are not cleared.
// A result waiting on the master side does not stop new items; a second finished query
// waits in the datapath, and holds off the input, until the first result is transferred.
module trilinear_volume_interpolator #(
    parameter int DIM_MAX      = 32,
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [14:0] coord_x, [29:15] coord_y, [44:30] coord_z, [60:45] sample_in, [63:61] zero
    input  logic [tvi_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [0] command
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [15:0] interpolated
    output logic [tvi_pkg::OUT_W-1:0]      o_m_axis_tdata,
    // [0] clipped
    output logic                           o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tvi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tvi_pkg::CFG_W-1:0]      i_cfg_data
);
    import tvi_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tvi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    tvi_dp #(
        .DIM_MAX      (DIM_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
